### rtl/asd_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants for the adaptive sample decimator
// no dependencies; used by asd_div, adaptive_sample_decimator, asd_checker and tb
package asd_pkg;

    // shared divider operand widths
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

    // input commands
    localparam logic [2:0] CMD_SAMPLE = 3'd0;
    localparam logic [2:0] CMD_BATCH  = 3'd1;
    localparam logic [2:0] CMD_DRAIN  = 3'd2;
    localparam logic [2:0] CMD_TICK   = 3'd3;
    localparam logic [2:0] CMD_ENABLE = 3'd4;

    // result actions
    localparam logic [1:0] ACT_SKIP  = 2'd0;
    localparam logic [1:0] ACT_STAGE = 2'd1;
    localparam logic [1:0] ACT_DROP  = 2'd2;
    localparam logic [1:0] ACT_OTHER = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ODR     = 2'd0;
    localparam logic [1:0] CFG_LOG     = 2'd1;
    localparam logic [1:0] CFG_PREVIEW = 2'd2;

    localparam logic [10:0] BUDGET_IDLE  = 11'd1300;
    localparam logic [10:0] BUDGET_LOG   = 11'd500;
    localparam logic [9:0]  WINDOW_LEN   = 10'd1000;
    localparam logic [13:0] PROBE_RECENT = 14'd10000;
    localparam logic [4:0]  CALM_CAP     = 5'd30;
    localparam logic [4:0]  CALM_STEP    = 5'd5;
    localparam logic [4:0]  CALM_MAX     = 5'd31;
    localparam logic [31:0] DROP_LIMIT   = 32'd10;
    localparam logic [2:0]  SHIFT_MAX    = 3'd4;
    localparam logic [7:0]  DECIM_MAX    = 8'd255;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quot;
        logic [DIVISOR_W-1:0]  rem;
    } t_div_res;

    // sensor output data rate in hertz per rate code
    function automatic logic [12:0] rate_hz(input logic [3:0] code);
        logic [12:0] hz;
        case (code)
            4'd1:    hz = 13'd13;
            4'd2:    hz = 13'd26;
            4'd3:    hz = 13'd52;
            4'd4:    hz = 13'd104;
            4'd5:    hz = 13'd208;
            4'd6:    hz = 13'd416;
            4'd7:    hz = 13'd833;
            4'd8:    hz = 13'd1660;
            4'd9:    hz = 13'd3330;
            4'd10:   hz = 13'd6660;
            default: hz = 13'd0;
        endcase
        return hz;
    endfunction

endpackage

### rtl/asd_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, 32 steps per division
// depends on asd_pkg for the request and result structs
module asd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  asd_pkg::t_div_req i_req,
    output asd_pkg::t_div_res o_res
);

    logic                           r_busy;
    logic                           r_done;
    logic [asd_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [asd_pkg::DIVISOR_W-1:0]  r_rem;
    logic [asd_pkg::DIVIDEND_W-1:0] r_quo;
    logic [asd_pkg::DIVISOR_W-1:0]  r_dvs;

    logic [asd_pkg::DIVISOR_W:0] trial;
    logic [asd_pkg::DIVISOR_W:0] diff;
    logic                        fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {r_rem, r_quo[asd_pkg::DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == asd_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[asd_pkg::DIVISOR_W-1:0] : trial[asd_pkg::DIVISOR_W-1:0];
            r_quo <= {r_quo[asd_pkg::DIVIDEND_W-2:0], fits};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quo;
    assign o_res.rem  = r_rem;

endmodule

### rtl/adaptive_sample_decimator.sv
`timescale 1ns / 1ps
// adaptive sample decimator: fifo bookkeeping, decimation and drop-driven backoff
// depends on asd_pkg and asd_div (shared divider for modulo and base factor)
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  s_*     | in        | s_tvalid / s_tready   | tuser cmd, tdata drain_count, send_ok
//  m_*     | out       | m_tvalid / m_tready   | tuser action, tdata slot..shift
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// a sample item runs accept, 32 divider steps for index mod factor, result load
// a stream enable item also runs the divider for the base factor
// other items go straight to result load; a register write reruns the base factor divider
// reset is synchronous; the base factor comes up as 1 with no divider pass
// the block takes no item until the previous result is loaded into the output register
module adaptive_sample_decimator #(
    parameter int FIFO_DEPTH     = 256,
    parameter int PACKET_SAMPLES = 14,
    localparam int SLOT_W   = $clog2(FIFO_DEPTH),
    localparam int LVL_W    = $clog2(FIFO_DEPTH + 1),
    localparam int FIELD_W  = SLOT_W + LVL_W + 32 + 8 + 3,
    localparam int M_DATA_W = ((FIELD_W + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // drain_count [3:0], send_ok [4]
    input  logic [2:0]          s_tuser,   // cmd
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // write_slot, fifo_level, dropped_total,
                                           // effective_decim, adapt_shift
    output logic [1:0]          m_tuser,   // action
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MOD  = 4'b0010,
        ST_BASE = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state r_state;

    logic [3:0]        r_odr;
    logic              r_log;
    logic [15:0]       r_prev;
    logic [7:0]        r_base;
    logic [2:0]        r_shift;
    logic [4:0]        r_calm;
    logic [4:0]        r_need;
    logic [31:0]       r_prior;
    logic [31:0]       r_drop;
    logic [31:0]       r_sidx;
    logic [LVL_W-1:0]  r_fill;
    logic [SLOT_W-1:0] r_head;
    logic [9:0]        r_win;
    logic [13:0]       r_since;
    logic              r_base_emit;
    logic [1:0]        r_act;
    logic [SLOT_W-1:0] r_slot;
    logic              r_m_valid;
    logic [M_DATA_W-1:0] r_m_tdata;
    logic [1:0]        r_m_tuser;

    logic              s_acc;
    logic              cfg_acc;
    logic              cfg_known;
    logic [2:0]        cmd;
    logic [3:0]        dcount;
    logic              send_ok;
    logic [3:0]        c_odr;
    logic              c_log;
    logic [15:0]       c_prev;
    logic [10:0]       target;
    logic [11:0]       eff_wide;
    logic [7:0]        eff;
    logic [31:0]       drops;
    logic [4:0]        calm_inc;
    logic [3:0]        drain_n;
    logic              out_free;
    logic [7:0]        base_q;
    asd_pkg::t_div_req div_req;
    asd_pkg::t_div_res div_res;

    assign cmd     = s_tuser;
    assign dcount  = s_tdata[3:0];
    assign send_ok = s_tdata[4];

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign s_tready    = (r_state == ST_IDLE) && !i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign s_acc       = s_tvalid && s_tready;
    assign out_free    = !r_m_valid || m_tready;

    always_comb begin
        c_odr     = r_odr;
        c_log     = r_log;
        c_prev    = r_prev;
        cfg_known = 1'b0;
        if (cfg_acc) begin
            unique case (i_cfg_index)
                asd_pkg::CFG_ODR: begin
                    c_odr     = i_cfg_data[3:0];
                    cfg_known = 1'b1;
                end
                asd_pkg::CFG_LOG: begin
                    c_log     = i_cfg_data[0];
                    cfg_known = 1'b1;
                end
                asd_pkg::CFG_PREVIEW: begin
                    c_prev    = i_cfg_data;
                    cfg_known = 1'b1;
                end
                default: cfg_known = 1'b0;
            endcase
        end
    end

    // link budget, lowered by a nonzero preview rate
    always_comb begin
        target = c_log ? asd_pkg::BUDGET_LOG : asd_pkg::BUDGET_IDLE;
        if (c_prev != 16'd0 && c_prev < {5'd0, target}) begin
            target = c_prev[10:0];
        end
    end

    assign eff_wide = {4'd0, r_base} << r_shift;
    assign eff      = (|eff_wide[11:8]) ? asd_pkg::DECIM_MAX : eff_wide[7:0];
    assign drops    = r_drop - r_prior;
    assign calm_inc = (r_calm < asd_pkg::CALM_MAX) ? r_calm + 5'd1 : r_calm;

    always_comb begin
        drain_n = dcount;
        if (LVL_W'(drain_n) > r_fill) begin
            drain_n = r_fill[3:0];
        end
        if (int'(drain_n) > PACKET_SAMPLES) begin
            drain_n = 4'(PACKET_SAMPLES);
        end
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = 32'd0;
        div_req.divisor  = 16'd0;
        if (s_acc && cmd == asd_pkg::CMD_SAMPLE) begin
            div_req.start    = 1'b1;
            div_req.dividend = r_sidx;
            div_req.divisor  = {8'd0, eff};
        end else if (cfg_known || (s_acc && cmd == asd_pkg::CMD_ENABLE)) begin
            // ceiling of rate over budget
            div_req.start    = 1'b1;
            div_req.dividend = 32'(asd_pkg::rate_hz(c_odr)) + 32'(target) - 32'd1;
            div_req.divisor  = 16'(target);
        end
    end

    asd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    always_comb begin
        if (div_res.quot == 32'd0) begin
            base_q = 8'd1;
        end else if (div_res.quot > 32'(asd_pkg::DECIM_MAX)) begin
            base_q = asd_pkg::DECIM_MAX;
        end else begin
            base_q = div_res.quot[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_odr       <= '0;
            r_log       <= 1'b0;
            r_prev      <= '0;
            r_base      <= 8'd1;
            r_shift     <= '0;
            r_calm      <= '0;
            r_need      <= asd_pkg::CALM_STEP;
            r_prior     <= '0;
            r_drop      <= '0;
            r_sidx      <= '0;
            r_fill      <= '0;
            r_head      <= '0;
            r_win       <= '0;
            r_since     <= asd_pkg::PROBE_RECENT;
            r_base_emit <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (r_state == ST_EMIT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (cfg_acc) begin
                        r_odr  <= c_odr;
                        r_log  <= c_log;
                        r_prev <= c_prev;
                    end
                    if (cfg_known || (s_acc && cmd == asd_pkg::CMD_ENABLE)) begin
                        r_shift <= '0;
                        r_calm  <= '0;
                        r_need  <= asd_pkg::CALM_STEP;
                        r_since <= asd_pkg::PROBE_RECENT;
                        r_win   <= '0;
                    end
                    if (cfg_known) begin
                        r_base_emit <= 1'b0;
                        r_state     <= ST_BASE;
                    end else if (s_acc) begin
                        r_act  <= asd_pkg::ACT_OTHER;
                        r_slot <= '0;
                        case (cmd)
                            asd_pkg::CMD_SAMPLE: begin
                                r_sidx  <= r_sidx + 32'd1;
                                r_state <= ST_MOD;
                            end
                            asd_pkg::CMD_BATCH: begin
                                r_state <= ST_EMIT;
                                if (r_win >= asd_pkg::WINDOW_LEN) begin
                                    r_win   <= '0;
                                    r_prior <= r_drop;
                                    if (drops > asd_pkg::DROP_LIMIT) begin
                                        if (r_shift < asd_pkg::SHIFT_MAX) begin
                                            r_shift <= r_shift + 3'd1;
                                        end
                                        if (r_since < asd_pkg::PROBE_RECENT &&
                                            r_need < asd_pkg::CALM_CAP) begin
                                            r_need <= r_need + asd_pkg::CALM_STEP;
                                        end
                                        r_calm <= '0;
                                    end else if (drops == 32'd0) begin
                                        // calm window: probe one step down when calm long enough
                                        if (calm_inc >= r_need && r_shift != 3'd0) begin
                                            r_shift <= r_shift - 3'd1;
                                            r_since <= '0;
                                            r_calm  <= '0;
                                        end else begin
                                            r_calm <= calm_inc;
                                        end
                                    end else begin
                                        r_calm <= '0;
                                    end
                                end
                            end
                            asd_pkg::CMD_DRAIN: begin
                                r_state <= ST_EMIT;
                                r_fill  <= r_fill - LVL_W'(drain_n);
                                if (!send_ok) begin
                                    r_drop <= r_drop + 32'(drain_n);
                                end
                            end
                            asd_pkg::CMD_TICK: begin
                                r_state <= ST_EMIT;
                                if (r_win < asd_pkg::WINDOW_LEN) begin
                                    r_win <= r_win + 10'd1;
                                end
                                if (r_since < asd_pkg::PROBE_RECENT) begin
                                    r_since <= r_since + 14'd1;
                                end
                            end
                            asd_pkg::CMD_ENABLE: begin
                                r_fill      <= '0;
                                r_sidx      <= '0;
                                r_drop      <= '0;
                                r_prior     <= '0;
                                r_base_emit <= 1'b1;
                                r_state     <= ST_BASE;
                            end
                            default: r_state <= ST_EMIT;
                        endcase
                    end
                end
                ST_MOD: begin
                    if (div_res.done) begin
                        r_state <= ST_EMIT;
                        if (div_res.rem != 16'd0) begin
                            r_act <= asd_pkg::ACT_SKIP;
                        end else if (r_fill >= LVL_W'(FIFO_DEPTH)) begin
                            r_act  <= asd_pkg::ACT_DROP;
                            r_drop <= r_drop + 32'd1;
                        end else begin
                            r_act  <= asd_pkg::ACT_STAGE;
                            r_slot <= r_head;
                            r_head <= (r_head == SLOT_W'(FIFO_DEPTH - 1)) ? '0
                                                                          : r_head + 1'b1;
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                ST_BASE: begin
                    if (div_res.done) begin
                        r_base  <= base_q;
                        r_state <= r_base_emit ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_m_tuser <= r_act;
            r_m_tdata <= M_DATA_W'({r_shift, eff, r_drop, r_fill, r_slot});
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

endmodule

### verif/asd_checker.sv
`timescale 1ns / 1ps
// result checker for the adaptive sample decimator: follows items and register writes,
// keeps its own decimation and backoff state and compares every result item
// depends on asd_pkg for command, action and register codes and the adaptation constants
module asd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,       // drain_count [3:0], send_ok [4]
    input  logic [2:0]  s_tuser,       // cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,       // write_slot, fifo_level, dropped_total,
                                       // effective_decim, adapt_shift
    input  logic [1:0]  m_tuser,       // action
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_staged,
    output int          o_dropped,
    output int          o_peak_shift,
    output int          o_peak_level
);
    import asd_pkg::*;

    localparam int FIFO_SLOTS = 256;
    localparam int PACKET_MAX = 14;
    localparam int MAX_REPORTS = 10;

    // fields from the highest bit down, so {m_tdata[59:0], m_tuser} maps straight on
    typedef struct packed {
        logic [2:0]  shift;
        logic [7:0]  decim;
        logic [31:0] dropped;
        logic [8:0]  level;
        logic [7:0]  slot;
        logic [1:0]  action;
    } dec_result_t;

    logic [3:0]  reg_odr;
    logic        reg_log;
    logic [15:0] reg_preview;
    logic [7:0]  base_factor;
    logic [2:0]  shift_cur;
    logic [4:0]  calm_secs;
    logic [4:0]  calm_goal;
    logic [31:0] drops_at_window;
    logic [31:0] drop_cnt;
    logic [31:0] sample_cnt;
    logic [8:0]  fill;
    logic [7:0]  head;
    logic [9:0]  win_ms;
    logic [13:0] probe_age_ms;

    dec_result_t due_results[$];
    dec_result_t got;
    dec_result_t want;
    string       diff;
    int          fails;
    int          n_checked;
    int          n_staged;
    int          n_dropped;
    int          peak_shift;
    int          peak_level;

    function automatic int odr_rate_hz(input logic [3:0] code);
        case (code)
            4'd1:    return 13;
            4'd2:    return 26;
            4'd3:    return 52;
            4'd4:    return 104;
            4'd5:    return 208;
            4'd6:    return 416;
            4'd7:    return 833;
            4'd8:    return 1660;
            4'd9:    return 3330;
            4'd10:   return 6660;
            default: return 0;
        endcase
    endfunction

    // new base factor from the registers, adaptation starts over
    function automatic void restart_adaptation();
        int hz;
        int budget;
        int factor;
        hz = odr_rate_hz(reg_odr);
        budget = reg_log ? int'(BUDGET_LOG) : int'(BUDGET_IDLE);
        if (reg_preview != 16'd0 && int'(reg_preview) < budget)
            budget = int'(reg_preview);
        factor = (hz + budget - 1) / budget;
        if (factor < 1)
            factor = 1;
        if (factor > int'(DECIM_MAX))
            factor = int'(DECIM_MAX);
        base_factor = 8'(factor);
        shift_cur = '0;
        calm_secs = '0;
        calm_goal = CALM_STEP;  // calm period starts at one step
        probe_age_ms = PROBE_RECENT;
        win_ms = '0;
    endfunction

    function automatic logic [7:0] eff_factor();
        int f;
        f = int'(base_factor) << shift_cur;
        return (f > int'(DECIM_MAX)) ? DECIM_MAX : 8'(f);
    endfunction

    function automatic void close_window();
        logic [31:0] fresh;
        if (win_ms < WINDOW_LEN)
            return;
        win_ms = '0;
        fresh = drop_cnt - drops_at_window;
        drops_at_window = drop_cnt;
        if (fresh > DROP_LIMIT) begin
            if (shift_cur < SHIFT_MAX)
                shift_cur = shift_cur + 3'd1;
            // backing off soon after a probe makes the next probe wait longer
            if (probe_age_ms < PROBE_RECENT && calm_goal < CALM_CAP)
                calm_goal = calm_goal + CALM_STEP;
            calm_secs = '0;
        end else if (fresh == 32'd0) begin
            if (calm_secs < CALM_MAX)
                calm_secs = calm_secs + 5'd1;
            if (calm_secs >= calm_goal && shift_cur != 3'd0) begin
                shift_cur = shift_cur - 3'd1;
                probe_age_ms = '0;
                calm_secs = '0;
            end
        end else begin
            calm_secs = '0;
        end
    endfunction

    function automatic void write_reg(input logic [1:0] idx, input logic [15:0] data);
        if (idx > CFG_PREVIEW)
            return;
        case (idx)
            CFG_ODR:     reg_odr = data[3:0];
            CFG_LOG:     reg_log = data[0];
            default:     reg_preview = data;
        endcase
        restart_adaptation();
    endfunction

    function automatic dec_result_t predict_item(input logic [2:0] cmd, input logic [3:0] cnt,
                                                 input logic ok);
        dec_result_t r;
        logic [31:0] divisor;
        logic [8:0]  take;
        r = '0;
        r.action = ACT_OTHER;
        case (cmd)
            CMD_SAMPLE: begin
                divisor = {24'd0, eff_factor()};
                if (sample_cnt % divisor != 32'd0) begin
                    r.action = ACT_SKIP;
                end else if (int'(fill) >= FIFO_SLOTS) begin
                    drop_cnt = drop_cnt + 32'd1;
                    r.action = ACT_DROP;
                end else begin
                    r.slot = head;
                    head = (int'(head) + 1 >= FIFO_SLOTS) ? 8'd0 : head + 8'd1;
                    fill = fill + 9'd1;
                    r.action = ACT_STAGE;
                end
                sample_cnt = sample_cnt + 32'd1;
            end
            CMD_BATCH: begin
                close_window();
            end
            CMD_DRAIN: begin
                take = {5'd0, cnt};
                if (take > fill)
                    take = fill;
                if (int'(take) > PACKET_MAX)
                    take = 9'(PACKET_MAX);
                fill = fill - take;
                // a failed packet loses what it carried
                if (!ok)
                    drop_cnt = drop_cnt + {23'd0, take};
            end
            CMD_TICK: begin
                if (win_ms < WINDOW_LEN)
                    win_ms = win_ms + 10'd1;
                if (probe_age_ms < PROBE_RECENT)
                    probe_age_ms = probe_age_ms + 14'd1;
            end
            CMD_ENABLE: begin
                fill = '0;
                sample_cnt = '0;
                drop_cnt = '0;
                drops_at_window = '0;
                restart_adaptation();
            end
            default: begin
            end
        endcase
        r.level = fill;
        r.dropped = drop_cnt;
        r.decim = eff_factor();
        r.shift = shift_cur;
        return r;
    endfunction

    function automatic string fmt_result(input dec_result_t r);
        return $sformatf("act=%0d slot=%0d level=%0d dropped=%0d decim=%0d shift=%0d",
                         r.action, r.slot, r.level, r.dropped, r.decim, r.shift);
    endfunction

    function automatic void note_failure(input string msg);
        fails++;
        if (fails <= MAX_REPORTS)
            $display("check error: %s", msg);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_odr = '0;
            reg_log = 1'b0;
            reg_preview = '0;
            drops_at_window = '0;
            drop_cnt = '0;
            sample_cnt = '0;
            fill = '0;
            head = '0;
            restart_adaptation();
            due_results.delete();
            fails = 0;
            n_checked = 0;
            n_staged = 0;
            n_dropped = 0;
            peak_shift = 0;
            peak_level = 0;
        end else begin
            // results leave before new items come in: a result never belongs to an item
            // taken at the same edge
            if (m_tvalid && m_tready) begin
                got = {m_tdata[59:0], m_tuser};
                n_checked++;
                if (got.action == ACT_STAGE)
                    n_staged++;
                if (got.action == ACT_DROP)
                    n_dropped++;
                if (int'(got.shift) > peak_shift)
                    peak_shift = int'(got.shift);
                if (int'(got.level) > peak_level)
                    peak_level = int'(got.level);
                if (due_results.size() == 0) begin
                    note_failure($sformatf("result %0d with nothing expected: %s",
                                           n_checked, fmt_result(got)));
                end else begin
                    want = due_results.pop_front();
                    diff = "";
                    if (got.action !== want.action)
                        diff = {diff, " action"};
                    if (got.slot !== want.slot)
                        diff = {diff, " write_slot"};
                    if (got.level !== want.level)
                        diff = {diff, " fifo_level"};
                    if (got.dropped !== want.dropped)
                        diff = {diff, " dropped_total"};
                    if (got.decim !== want.decim)
                        diff = {diff, " effective_decim"};
                    if (got.shift !== want.shift)
                        diff = {diff, " adapt_shift"};
                    if (diff != "")
                        note_failure($sformatf("result %0d differs in%s: expected %s, got %s",
                                               n_checked, diff, fmt_result(want),
                                               fmt_result(got)));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                write_reg(i_cfg_index, i_cfg_data);
            if (s_tvalid && s_tready)
                due_results.push_back(predict_item(s_tuser, s_tdata[3:0], s_tdata[4]));
        end
        o_fail_count <= fails;
        o_pending <= due_results.size();
        o_checked <= n_checked;
        o_staged <= n_staged;
        o_dropped <= n_dropped;
        o_peak_shift <= peak_shift;
        o_peak_level <= peak_level;
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// testbench top for the adaptive sample decimator: clock, reset, items, register writes
// and the verdict; depends on asd_pkg, adaptive_sample_decimator and asd_checker
module tb;

    localparam logic [1:0] CFG_SPARE    = 2'd3;   // past the register list, must be ignored
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int RX_HOLD_CYCLES = 400;
    // worst quiet stretch is a receiver hold plus one sample item and a register write
    localparam int IDLE_LIMIT     = 5000;
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_ITEMS    = 2;
    localparam int RATE_SETTINGS  = 10;
    localparam int SAMPLE_BURST   = 6;
    localparam int TICK_BURST     = 4;
    localparam int FILL_SAMPLES   = 260;

    typedef enum logic [1:0] {WIN_CALM, WIN_LIGHT, WIN_STORM} t_window_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'd0;
    logic [2:0]  s_tuser = 3'd0;
    logic        m_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [15:0] i_cfg_data = 16'd0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        o_cfg_ready;

    int   fail_count;
    int   pending;
    int   n_checked;
    int   n_staged;
    int   n_dropped;
    int   peak_shift;
    int   peak_level;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   n_sent = 0;
    int   n_settings = 0;
    int   idle_cycles = 0;

    adaptive_sample_decimator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    asd_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (n_checked),
        .o_staged     (n_staged),
        .o_dropped    (n_dropped),
        .o_peak_shift (peak_shift),
        .o_peak_level (peak_level)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: random stalls, or a long hold when asked for
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_tready <= rx_steady || ($urandom_range(99) >= 13);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [3:0] rnd_cnt();
        return 4'($urandom_range(15));
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(1));
    endfunction

    task automatic send_item(input logic [2:0] cmd, input logic [3:0] cnt, input logic ok);
        while (!tx_steady && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {3'b000, ok, cnt};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        n_sent++;
    endtask

    // stop offering items until every result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    task automatic configure(input logic [3:0] odr, input logic log_on,
                             input logic [15:0] preview);
        logic [31:0] junk;
        junk = $urandom;
        settle();
        // unused upper data bits carry noise
        write_reg(asd_pkg::CFG_ODR, {junk[15:4], odr});
        write_reg(asd_pkg::CFG_LOG, {junk[31:17], log_on});
        if (junk[3:0] < 4'd5)
            write_reg(CFG_SPARE, junk[31:16]);
        write_reg(asd_pkg::CFG_PREVIEW, preview);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic random_phase(input int quota);
        int done;
        int pick;
        int len;
        done = 0;
        while (done < quota) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                len = $urandom_range(1, SAMPLE_BURST);
                repeat (len) send_item(asd_pkg::CMD_SAMPLE, rnd_cnt(), rnd_bit());
                done += len;
            end else if (pick < 60) begin
                send_item(asd_pkg::CMD_DRAIN, rnd_cnt(), $urandom_range(3) != 0);
                done++;
            end else if (pick < 80) begin
                len = $urandom_range(1, TICK_BURST);
                repeat (len) send_item(asd_pkg::CMD_TICK, rnd_cnt(), rnd_bit());
                done += len;
            end else if (pick < 88) begin
                send_item(asd_pkg::CMD_BATCH, rnd_cnt(), rnd_bit());
                done++;
            end else if (pick < 92) begin
                send_item(asd_pkg::CMD_ENABLE, rnd_cnt(), rnd_bit());
                done++;
            end else begin
                send_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), rnd_cnt(),
                          rnd_bit());
                done++;
            end
        end
    endtask

    // one adaptation window: at least a second of ticks, one drain, a few samples
    task automatic run_window(input t_window_kind kind);
        int ticks;
        int spot;
        int i;
        ticks = int'(asd_pkg::WINDOW_LEN) + int'($urandom_range(4));
        spot = $urandom_range(100, 900);
        for (i = 0; i < ticks; i++) begin
            send_item(asd_pkg::CMD_TICK, rnd_cnt(), rnd_bit());
            if (i == spot) begin
                case (kind)
                    WIN_STORM: send_item(asd_pkg::CMD_DRAIN, 4'd14, 1'b0);
                    WIN_LIGHT: send_item(asd_pkg::CMD_DRAIN, 4'($urandom_range(1, 10)), 1'b0);
                    default:   send_item(asd_pkg::CMD_DRAIN, rnd_cnt(), 1'b1);
                endcase
            end
            if ($urandom_range(99) < 1)
                send_item(asd_pkg::CMD_SAMPLE, rnd_cnt(), rnd_bit());
            // an early batch end leaves the window open
            if (i == ticks / 2)
                send_item(asd_pkg::CMD_BATCH, rnd_cnt(), rnd_bit());
        end
        send_item(asd_pkg::CMD_BATCH, rnd_cnt(), rnd_bit());
    endtask

    initial begin
        int ph;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: samples before any enable, drain clipping, lost packets, spare codes
        repeat (3) send_item(asd_pkg::CMD_SAMPLE, 4'd0, 1'b0);
        send_item(asd_pkg::CMD_DRAIN, 4'd15, 1'b1);
        send_item(asd_pkg::CMD_ENABLE, 4'd15, 1'b1);
        repeat (2) send_item(asd_pkg::CMD_SAMPLE, 4'd15, 1'b1);
        send_item(asd_pkg::CMD_DRAIN, 4'd1, 1'b0);
        send_item(asd_pkg::CMD_DRAIN, 4'd0, 1'b0);
        send_item(asd_pkg::CMD_DRAIN, 4'd14, 1'b0);
        send_item(asd_pkg::CMD_TICK, 4'd0, 1'b0);
        send_item(asd_pkg::CMD_BATCH, 4'd0, 1'b0);
        send_item(CMD_SPARE_LO, 4'd15, 1'b1);
        send_item(CMD_SPARE_LO + 3'd1, 4'd0, 1'b0);
        send_item(CMD_SPARE_HI, 4'd10, 1'b1);
        send_item(asd_pkg::CMD_DRAIN, 4'd15, 1'b0);
        send_item(asd_pkg::CMD_SAMPLE, 4'd5, 1'b0);

        // rate and budget settings, extremes included
        for (ph = 0; ph < RATE_SETTINGS; ph++) begin
            case (ph)
                0:       configure(4'd10, 1'b0, 16'd0);      // factor 6
                1:       configure(4'd10, 1'b1, 16'd0);      // factor 14
                2:       configure(4'd10, 1'b0, 16'd1);      // clamps at 255
                3:       configure(4'd15, 1'b1, 16'hFFFF);   // unknown code, factor 1
                4:       configure(4'd7, 1'b0, 16'd833);
                5:       configure(4'd9, 1'b1, 16'd499);
                6:       configure(4'd5, 1'b0, 16'hFFFF);
                7:       configure(4'd10, 1'b1, 16'd26);
                8:       configure(4'd11, 1'b0, 16'd100);
                default: configure(4'd6, 1'b1, 16'd3);
            endcase
            if (ph == 1)
                hold_req <= hold_req + 1;
            if ($urandom_range(1))
                send_item(asd_pkg::CMD_ENABLE, rnd_cnt(), rnd_bit());
            random_phase(PHASE_ITEMS);
        end

        // fill the fifo past full with no idling on either side
        configure(4'd0, 1'b0, 16'd0);
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        send_item(asd_pkg::CMD_ENABLE, 4'd0, 1'b0);
        repeat (FILL_SAMPLES) send_item(asd_pkg::CMD_SAMPLE, rnd_cnt(), rnd_bit());
        tx_steady = 1'b0;
        rx_steady <= 1'b0;

        // a stormy window while the fifo is full backs the factor off one step
        run_window(WIN_STORM);
        repeat (6) send_item(asd_pkg::CMD_SAMPLE, rnd_cnt(), rnd_bit());
        repeat (2) send_item(asd_pkg::CMD_DRAIN, 4'd14, rnd_bit());

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d items over %0d register settings, %0d results checked", n_sent,
                 n_settings, n_checked);
        $display("%0d staged, %0d dropped by full fifo, peak shift %0d, peak fifo level %0d",
                 n_staged, n_dropped, peak_shift, peak_level);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors, %0d results missing", fail_count, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
